// ----- design/assert_macros.svh -----
// assertion helpers for the rtl files (included by the matcher)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge, ignored while reset is applied
`define GWM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property checked on every clock edge, also during reset
`define GWM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/gwm_pkg.sv -----
`default_nettype none

package gwm_pkg;

	// operation codes carried with each input transaction
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_TEXT   = 2'd2,
		OP_END    = 2'd3
	} op_t;

	// pattern bytes with a wildcard meaning
	localparam logic [7:0] SYM_ANY_ONE = 8'h3F;
	localparam logic [7:0] SYM_ANY_RUN = 8'h2A;

endpackage

`default_nettype wire

// ----- design/gwm_channels.sv -----
`default_nettype none

// input channel: operation and symbol
interface gwm_in_if;
	import gwm_pkg::*;

	logic       valid;
	logic       ready;
	op_t        op;
	logic [7:0] symbol;

	modport source (output valid, output op, output symbol, input ready);
	modport sink (input valid, input op, input symbol, output ready);
endinterface

// result channel: match verdict and overflow status
interface gwm_out_if;
	logic valid;
	logic ready;
	logic matched;
	logic pattern_overflow;

	modport source (output valid, output matched, output pattern_overflow, input ready);
	modport sink (input valid, input matched, input pattern_overflow, output ready);
endinterface

`default_nettype wire

// ----- design/glob_wildcard_matcher.sv -----
`default_nettype none

// Glob matcher: stores a pattern of up to MAX_PATTERN bytes, where '?' matches any one
// byte and '*' any run of bytes (also empty), and checks streamed text against it.
// Op clear empties the pattern and restarts the text; op append adds a pattern byte
// (bytes past capacity are dropped and flagged); op text feeds one text byte; op end
// returns one result transaction (matched, pattern_overflow) and restarts the text.
// Only op end produces a result. Throughput is one transaction per cycle: every pattern
// position is updated in parallel in the single stage between the input register and
// the result register, with the star closure done as a log-depth prefix network of
// clog2(MAX_PATTERN+1) levels. An end's verdict goes from the input register to the result register.
// The input side holds only when an end-of-text transaction sits in the input register
// while the previous result is still waiting in the result register.
module glob_wildcard_matcher #(
	parameter int MAX_PATTERN = 32
) (
	input  wire  clk,
	input  wire  arst_n,
	gwm_in_if.sink    items,
	gwm_out_if.source results
);
	import gwm_pkg::*;

	`include "assert_macros.svh"

	localparam int N   = MAX_PATTERN + 1;
	localparam int LW  = $clog2(N);
	localparam int LVL = $clog2(N);

	// input register
	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] symbol_s1;

	// matcher state
	logic [7:0]    pat_q [MAX_PATTERN];
	logic [LW-1:0] len_q;
	logic [N-1:0]  active_q;
	logic          overflow_q;

	// result register
	logic out_valid_q;
	logic matched_q;
	logic overflow_out_q;

	logic          out_free;
	logic          advance;
	logic          fire_s1;
	logic [N-1:0]  in_pat;
	logic [N-1:0]  beyond;
	logic [N-1:0]  is_star;
	logic [N-1:0]  closed;
	logic [N-1:0]  next_active;

	// handshake and stage advance
	assign out_free      = !out_valid_q || results.ready;
	assign advance       = !valid_s1 || (op_s1 != OP_END) || out_free;
	assign fire_s1       = valid_s1 && advance;
	assign items.ready   = advance;
	assign results.valid = out_valid_q;
	assign results.matched          = matched_q;
	assign results.pattern_overflow = overflow_out_q;

	// per-position masks
	always_comb begin
		for (int i = 0; i < N; i++) begin
			in_pat[i] = (LW'(i) < len_q);
			beyond[i] = (LW'(i) > len_q);
			if (i < MAX_PATTERN) begin
				is_star[i] = (pat_q[i] == SYM_ANY_RUN);
			end else begin
				is_star[i] = 1'b0;
			end
		end
	end

	// star closure: a live position before a star also reaches the next one
	always_comb begin
		logic [N-1:0] g;
		logic [N-1:0] p;
		logic [N-1:0] gn;
		logic [N-1:0] pn;
		g    = active_q;
		p    = '0;
		for (int i = 1; i < N; i++) begin
			p[i] = is_star[i-1] && in_pat[i-1];
		end
		for (int k = 0; k < LVL; k++) begin
			gn = g;
			pn = p;
			for (int i = 0; i < N; i++) begin
				if (i >= (1 << k)) begin
					gn[i] = g[i] | (p[i] & g[i - (1 << k)]);
					pn[i] = p[i] & p[i - (1 << k)];
				end
			end
			g = gn;
			p = pn;
		end
		closed = g;
	end

	// advance the position set by one text byte
	always_comb begin
		next_active = '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (closed[i] && in_pat[i]) begin
				if (is_star[i]) begin
					next_active[i] = 1'b1;
				end else if (pat_q[i] == SYM_ANY_ONE || pat_q[i] == symbol_s1) begin
					next_active[i+1] = 1'b1;
				end
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && items.valid) begin
			op_s1     <= items.op;
			symbol_s1 <= items.symbol;
		end
	end

	// pattern byte store
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (fire_s1 && op_s1 == OP_APPEND && len_q == LW'(i)) begin
				pat_q[i] <= symbol_s1;
			end
		end
	end

	// length, position set and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			active_q   <= N'(1);
			overflow_q <= 1'b0;
		end else if (fire_s1) begin
			case (op_s1)
				OP_CLEAR: begin
					len_q      <= '0;
					active_q   <= N'(1);
					overflow_q <= 1'b0;
				end
				OP_APPEND: begin
					if (len_q < LW'(MAX_PATTERN)) begin
						len_q <= len_q + LW'(1);
						for (int i = 1; i < N; i++) begin
							if (len_q == LW'(i - 1)) begin
								active_q[i] <= 1'b0;
							end
						end
					end else begin
						overflow_q <= 1'b1;
					end
				end
				OP_TEXT: begin
					active_q <= next_active;
				end
				OP_END: begin
					active_q <= N'(1);
				end
				default: begin
					active_q <= active_q;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && op_s1 == OP_END) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && op_s1 == OP_END) begin
			matched_q      <= closed[len_q];
			overflow_out_q <= overflow_q;
		end
	end

	// checks
	`GWM_ASSERT(a_len_in_range, len_q <= LW'(MAX_PATTERN), "pattern length beyond capacity")
	`GWM_ASSERT(a_no_live_beyond_len, (active_q & beyond) == '0, "live position past pattern end")
	`GWM_ASSERT(a_overflow_when_full, overflow_q |-> (len_q == LW'(MAX_PATTERN)), "overflow flag set with room left")
	`GWM_ASSERT(a_result_from_end, $rose(out_valid_q) |-> $past(fire_s1 && op_s1 == OP_END), "result without end of text")

endmodule

`default_nettype wire

// ----- tb/tb_glob_wildcard_matcher.sv -----
`timescale 1ns / 100ps

module tb_glob_wildcard_matcher;
	import gwm_pkg::*;

	localparam int MAXP = 32;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic matched;
		logic overflow;
	} verdict_t;

	// glob matcher predictor plus the queue of verdicts still owed by the block
	class match_tracker;
		logic [7:0] pattern [MAXP];
		int plen;
		bit [MAXP:0] live;
		bit overflow;
		verdict_t expected_verdicts [$];
		int mismatches;

		function new();
			plen = 0;
			overflow = 1'b0;
			live = (MAXP+1)'(1);
			mismatches = 0;
		endfunction

		// a live position in front of a star also makes the next position live
		function void close_stars();
			for (int i = 0; i < plen; i++)
				if (live[i] && pattern[i] == SYM_ANY_RUN) live[i + 1] = 1'b1;
		endfunction

		function void step_text(logic [7:0] c);
			bit [MAXP:0] nxt;
			close_stars();
			nxt = '0;
			for (int i = 0; i < plen; i++) begin
				if (!live[i]) continue;
				if (pattern[i] == SYM_ANY_RUN) nxt[i] = 1'b1;
				else if (pattern[i] == SYM_ANY_ONE || pattern[i] == c) nxt[i + 1] = 1'b1;
			end
			live = nxt;
		endfunction

		// update state for one accepted input transaction
		function void absorb(op_t o, logic [7:0] s);
			verdict_t v;
			case (o)
				OP_CLEAR: begin
					plen = 0;
					overflow = 1'b0;
					live = (MAXP+1)'(1);
				end
				OP_APPEND: begin
					if (plen < MAXP) begin
						pattern[plen] = s;
						plen++;
						live[plen] = 1'b0;
					end else begin
						overflow = 1'b1;
					end
				end
				OP_TEXT: step_text(s);
				default: begin
					close_stars();
					v.matched = live[plen];
					v.overflow = overflow;
					expected_verdicts = {expected_verdicts, v};
					live = (MAXP+1)'(1);
				end
			endcase
		endfunction

		function void complain(string msg);
			if (mismatches < 10) $display("[%0t] mismatch: %s", $realtime, msg);
			mismatches++;
		endfunction

		// compare one accepted result transaction with the oldest expected verdict
		function void check_verdict(logic m, logic o);
			verdict_t want;
			if (expected_verdicts.size() == 0) begin
				complain($sformatf("unexpected result matched=%b overflow=%b", m, o));
				return;
			end
			want = expected_verdicts.pop_front();
			if (want.matched !== m)
				complain($sformatf("matched expected %b got %b", want.matched, m));
			if (want.overflow !== o)
				complain($sformatf("pattern_overflow expected %b got %b", want.overflow, o));
		endfunction

		function int outstanding();
			return expected_verdicts.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int cycle_count = 0;
	int items_sent = 0;
	int hold_cycles = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	match_tracker tracker = new();

	gwm_in_if in_ch();
	gwm_out_if out_ch();

	glob_wildcard_matcher #(.MAX_PATTERN(MAXP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(in_ch),
		.results(out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_glob_wildcard_matcher: errors");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic logic [7:0] pattern_symbol();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) return SYM_ANY_RUN;
		if (r < 45) return SYM_ANY_ONE;
		if (r < 85) return 8'h61 + 8'($urandom_range(0, 2));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] text_filler();
		case ($urandom_range(0, 5))
			0: return SYM_ANY_RUN;
			1: return SYM_ANY_ONE;
			2: return 8'($urandom_range(0, 255));
			default: return 8'h61 + 8'($urandom_range(0, 2));
		endcase
	endfunction

	// result side: check accepted transactions and throttle ready
	initial begin
		int gap;
		gap = 0;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				tracker.check_verdict(out_ch.matched, out_ch.pattern_overflow);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ch.ready <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				gap = pick_gap(rx_calm);
			end
		end
	end

	// offer one input transaction and wait until it is taken
	task automatic send(op_t o, logic [7:0] s);
		int gap;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= o;
		in_ch.symbol <= s;
		do @(posedge clk); while (!in_ch.ready);
		tracker.absorb(o, s);
		items_sent++;
	endtask

	task automatic wait_results();
		in_ch.valid <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
	endtask

	// clear, a pattern, then texts built to fit it with occasional damage
	task automatic run_sequence(int len);
		logic [7:0] pat_q [$];
		logic [7:0] txt [$];
		int mid;
		logic [7:0] b;
		send(OP_CLEAR, 8'($urandom_range(0, 255)));
		for (int i = 0; i < len; i++) begin
			b = pattern_symbol();
			if (pat_q.size() < MAXP) pat_q = {pat_q, b};
			send(OP_APPEND, b);
		end
		repeat ($urandom_range(1, 4)) begin
			txt.delete();
			foreach (pat_q[k]) begin
				if (pat_q[k] == SYM_ANY_RUN)
					repeat ($urandom_range(0, 3)) txt = {txt, text_filler()};
				else if (pat_q[k] == SYM_ANY_ONE)
					txt = {txt, 8'($urandom_range(0, 255))};
				else
					txt = {txt, pat_q[k]};
			end
			if ($urandom_range(0, 9) < 3) begin
				case ($urandom_range(0, 2))
					0: txt.insert($urandom_range(0, txt.size()), text_filler());
					1: if (txt.size() > 0) txt.delete($urandom_range(0, txt.size() - 1));
					default: begin
						if (txt.size() > 0)
							txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
					end
				endcase
			end
			// now and then the pattern grows in the middle of a text
			mid = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, txt.size())) : -1;
			foreach (txt[k]) begin
				if (k == mid) send(OP_APPEND, pattern_symbol());
				send(OP_TEXT, txt[k]);
			end
			send(OP_END, 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int len;
		int r;
		bit first;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.op <= OP_CLEAR;
		in_ch.symbol <= 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pattern, stars only, wildcard text bytes, append during text
		send(OP_END, 8'h00);
		send(OP_TEXT, 8'h00);
		send(OP_END, 8'hFF);
		send(OP_CLEAR, 8'hFF);
		send(OP_APPEND, SYM_ANY_RUN);
		send(OP_APPEND, SYM_ANY_RUN);
		send(OP_END, 8'h55);
		send(OP_TEXT, 8'hFF);
		send(OP_TEXT, SYM_ANY_RUN);
		send(OP_END, 8'hAA);
		send(OP_CLEAR, 8'h00);
		send(OP_APPEND, 8'h61);
		send(OP_APPEND, SYM_ANY_ONE);
		send(OP_TEXT, 8'h61);
		send(OP_APPEND, 8'h63);
		send(OP_TEXT, 8'h80);
		send(OP_TEXT, 8'h63);
		send(OP_END, 8'h00);
		send(OP_END, 8'h00);
		send(OP_TEXT, SYM_ANY_ONE);
		send(OP_END, 8'h00);
		wait_results();

		// receiver holds off while the sender keeps offering ends
		hold_cycles = 300;
		send(OP_CLEAR, 8'h00);
		send(OP_APPEND, SYM_ANY_ONE);
		repeat (20) begin
			send(OP_TEXT, 8'($urandom_range(0, 255)));
			send(OP_END, 8'($urandom_range(0, 255)));
		end
		wait_results();

		// random sequences and noise, the first length chosen to overfill the pattern
		first = 1'b1;
		while (items_sent < 1000) begin
			r = $urandom_range(0, 99);
			if (first) begin
				len = MAXP + 2;
				first = 1'b0;
			end else if (r < 85) len = $urandom_range(0, 8);
			else if (r < 95) len = $urandom_range(9, MAXP - 1);
			else len = $urandom_range(MAXP, MAXP + 3);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6))
					send(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else begin
				run_sequence(len);
			end
			if ($urandom_range(0, 7) == 0) tx_calm = !tx_calm;
			if ($urandom_range(0, 7) == 0) rx_calm = !rx_calm;
		end

		wait_results();
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.outstanding() == 0)
			$display("tb_glob_wildcard_matcher: clean");
		else
			$display("tb_glob_wildcard_matcher: errors");
		$finish;
	end

endmodule

// ----- glob_wildcard_matcher.f -----
+incdir+design
design/gwm_pkg.sv
design/gwm_channels.sv
design/glob_wildcard_matcher.sv
tb/tb_glob_wildcard_matcher.sv
